[hdl/fpwm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpwm_pkg
// Shared types and constants of the flow pulse window monitor.
// ----------------------------------------------------------------------------
package fpwm_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 16;

  localparam logic [COUNT_W-1:0] WINDOW_TICKS_RST = 16'd100;

  typedef enum logic {
    OP_POLL    = 1'b0,
    OP_CAPTURE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OFF     = 2'd0,
    ST_STARTED = 2'd1,
    ST_ON      = 2'd2,
    ST_STOPPED = 2'd3
  } flow_state_t;

  typedef struct packed {
    op_t                operation;
    logic [TIME_W-1:0]  sys_tick;
    logic [COUNT_W-1:0] live_pulse_count;
    logic [COUNT_W-1:0] capture_ticks;
    logic [COUNT_W-1:0] capture_pulses;
  } in_item_t;

  typedef struct packed {
    flow_state_t        flow_state;
    logic [COUNT_W-1:0] volume_delta;
    logic               rate_valid;
    logic [COUNT_W-1:0] rate_pulse_diff;
    logic [COUNT_W-1:0] rate_tick_diff;
    logic               point_symbol;
  } out_item_t;

  typedef struct packed {
    logic cap_armed;
    logic cap_pending;
  } eval_status_t;

endpackage

[hdl/fpwm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpwm_if
// Request, result and configuration channels of the flow pulse window monitor.
// ----------------------------------------------------------------------------
interface fpwm_in_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [fpwm_pkg::TIME_W-1:0]     sys_tick;
  logic [fpwm_pkg::COUNT_W-1:0]    live_pulse_count;
  logic [fpwm_pkg::COUNT_W-1:0]    capture_ticks;
  logic [fpwm_pkg::COUNT_W-1:0]    capture_pulses;

  modport source (output valid, operation, sys_tick, live_pulse_count,
                  capture_ticks, capture_pulses, input ready);
  modport sink   (input valid, operation, sys_tick, live_pulse_count,
                  capture_ticks, capture_pulses, output ready);
endinterface

interface fpwm_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      flow_state;
  logic [fpwm_pkg::COUNT_W-1:0]    volume_delta;
  logic                            rate_valid;
  logic [fpwm_pkg::COUNT_W-1:0]    rate_pulse_diff;
  logic [fpwm_pkg::COUNT_W-1:0]    rate_tick_diff;
  logic                            point_symbol;

  modport source (output valid, flow_state, volume_delta, rate_valid,
                  rate_pulse_diff, rate_tick_diff, point_symbol, input ready);
  modport sink   (input valid, flow_state, volume_delta, rate_valid,
                  rate_pulse_diff, rate_tick_diff, point_symbol, output ready);
endinterface

interface fpwm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fpwm_pkg::COUNT_W-1:0]    window_ticks;

  modport source (output valid, window_ticks, input ready);
  modport sink   (input valid, window_ticks, output ready);
endinterface

[hdl/fpwm_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpwm_eval
// Window state and per-request evaluation: capture latch, window check,
// volume and rate deltas, flow status and blink phase.
// ----------------------------------------------------------------------------
module fpwm_eval (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  fpwm_pkg::in_item_t             item,
  input  logic [fpwm_pkg::COUNT_W-1:0]   window_ticks,
  output logic                           has_result,
  output fpwm_pkg::out_item_t            result,
  output fpwm_pkg::eval_status_t         status
);

  logic [fpwm_pkg::TIME_W-1:0]  last_time_r;
  logic [fpwm_pkg::COUNT_W-1:0] last_live_r;
  logic [fpwm_pkg::COUNT_W-1:0] prev_pulses_r;
  logic [fpwm_pkg::COUNT_W-1:0] prev_ticks_r;
  logic [fpwm_pkg::COUNT_W-1:0] held_pulses_r;
  logic [fpwm_pkg::COUNT_W-1:0] held_ticks_r;
  logic                         cap_pending_r;
  logic                         cap_armed_r;
  fpwm_pkg::flow_state_t        state_r;
  fpwm_pkg::flow_state_t        state_nxt;
  logic                         blink_r;

  logic                         is_capture;
  logic [fpwm_pkg::TIME_W-1:0]  elapsed;
  logic                         window_open;
  logic [fpwm_pkg::COUNT_W-1:0] vol;
  logic                         moving;
  logic [fpwm_pkg::COUNT_W-1:0] pd_raw;
  logic [fpwm_pkg::COUNT_W-1:0] td_raw;
  logic                         rate_ok;

  assign is_capture  = (item.operation == fpwm_pkg::OP_CAPTURE);
  assign elapsed     = item.sys_tick - last_time_r;
  assign window_open = !is_capture &&
                       (elapsed >= {{(fpwm_pkg::TIME_W-fpwm_pkg::COUNT_W){1'b0}},
                                    window_ticks});
  assign vol         = item.live_pulse_count - last_live_r;
  assign moving      = (vol != '0);
  assign pd_raw      = held_pulses_r - prev_pulses_r;
  assign td_raw      = held_ticks_r - prev_ticks_r;
  assign rate_ok     = cap_pending_r && (td_raw > 16'd1);

  always_comb begin
    case (state_r)
      fpwm_pkg::ST_OFF:     state_nxt = moving ? fpwm_pkg::ST_STARTED : fpwm_pkg::ST_OFF;
      fpwm_pkg::ST_STARTED: state_nxt = moving ? fpwm_pkg::ST_ON : fpwm_pkg::ST_STOPPED;
      fpwm_pkg::ST_ON:      state_nxt = moving ? fpwm_pkg::ST_ON : fpwm_pkg::ST_STOPPED;
      fpwm_pkg::ST_STOPPED: state_nxt = moving ? fpwm_pkg::ST_STARTED : fpwm_pkg::ST_OFF;
      default:              state_nxt = fpwm_pkg::ST_OFF;
    endcase
  end

  assign has_result             = window_open;
  assign result.flow_state      = state_nxt;
  assign result.volume_delta    = vol;
  assign result.rate_valid      = rate_ok;
  assign result.rate_pulse_diff = rate_ok ? pd_raw : '0;
  assign result.rate_tick_diff  = rate_ok ? td_raw : '0;
  assign result.point_symbol    = moving & blink_r;

  assign status.cap_armed   = cap_armed_r;
  assign status.cap_pending = cap_pending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r   <= '0;
      last_live_r   <= '0;
      prev_pulses_r <= '0;
      prev_ticks_r  <= '0;
      held_pulses_r <= '0;
      held_ticks_r  <= '0;
      cap_pending_r <= 1'b0;
      cap_armed_r   <= 1'b1;
      state_r       <= fpwm_pkg::ST_OFF;
      blink_r       <= 1'b1;
    end else if (fire) begin
      if (is_capture && cap_armed_r) begin
        held_ticks_r  <= item.capture_ticks;
        held_pulses_r <= item.capture_pulses;
        cap_pending_r <= 1'b1;
        cap_armed_r   <= 1'b0;
      end
      if (window_open) begin
        last_time_r <= item.sys_tick;
        last_live_r <= item.live_pulse_count;
        if (cap_pending_r) begin
          prev_pulses_r <= held_pulses_r;
          prev_ticks_r  <= held_ticks_r;
          cap_pending_r <= 1'b0;
        end
        state_r     <= state_nxt;
        if (moving) begin
          blink_r <= ~blink_r;
        end
        cap_armed_r <= 1'b1;
      end
    end
  end

endmodule

[hdl/flow_pulse_window_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_pulse_window_monitor
// Flow-meter pulse window monitor: latches capture snapshots and, once per
// elapsed window, reports volume delta, flow status, rate deltas and blink.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_chan   in   valid / ready    operation, sys_tick, live_pulse_count,
//                                  capture_ticks, capture_pulses
//  out_chan  out  valid / ready    flow_state, volume_delta, rate_valid,
//                                  rate_pulse_diff, rate_tick_diff, point_symbol
//  cfg_chan  in   valid / ready    window_ticks
//
//  One request per cycle unless stalled; a request that opens a window is
//  held in the request register, its result then in the result register.
//  Reset (rst_n low, synchronous) restores window_ticks to 100, arms capture.
//  A request stalls in the request register only when it opens a window while
//  the result register holds an untaken result; cfg_chan is always ready.
// ----------------------------------------------------------------------------
module flow_pulse_window_monitor (
  input  logic              clk,
  input  logic              rst_n,
  fpwm_in_if.sink           in_chan,
  fpwm_out_if.source        out_chan,
  fpwm_cfg_if.sink          cfg_chan
);

  logic [fpwm_pkg::COUNT_W-1:0] window_r;
  logic                         req_valid_r;
  fpwm_pkg::in_item_t           req_r;
  logic                         out_valid_r;
  fpwm_pkg::out_item_t          out_r;

  logic                         req_fire;
  logic                         has_result;
  fpwm_pkg::out_item_t          result;
  fpwm_pkg::eval_status_t       eval_status;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= fpwm_pkg::WINDOW_TICKS_RST;
    end else if (cfg_chan.valid) begin
      window_r <= cfg_chan.window_ticks;
    end
  end

  assign req_fire      = req_valid_r && (!has_result || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !req_valid_r || req_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      req_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      req_r.operation        <= fpwm_pkg::op_t'(in_chan.operation);
      req_r.sys_tick         <= in_chan.sys_tick;
      req_r.live_pulse_count <= in_chan.live_pulse_count;
      req_r.capture_ticks    <= in_chan.capture_ticks;
      req_r.capture_pulses   <= in_chan.capture_pulses;
    end
  end

  fpwm_eval u_eval (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (req_fire),
    .item         (req_r),
    .window_ticks (window_r),
    .has_result   (has_result),
    .result       (result),
    .status       (eval_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_fire && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && has_result) begin
      out_r <= result;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.flow_state      = out_r.flow_state;
  assign out_chan.volume_delta    = out_r.volume_delta;
  assign out_chan.rate_valid      = out_r.rate_valid;
  assign out_chan.rate_pulse_diff = out_r.rate_pulse_diff;
  assign out_chan.rate_tick_diff  = out_r.rate_tick_diff;
  assign out_chan.point_symbol    = out_r.point_symbol;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !(req_fire && has_result))
    else $error("result register overwritten while held");

  a_arm_xor_pending: assert property (@(posedge clk) disable iff (!rst_n)
    eval_status.cap_armed != eval_status.cap_pending)
    else $error("capture armed and pending out of step");

  a_rate_valid_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.rate_valid) |-> (out_r.rate_tick_diff > 16'd1))
    else $error("rate valid with tick delta of one or less");

  a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.rate_valid) |->
      (out_r.rate_tick_diff == '0 && out_r.rate_pulse_diff == '0))
    else $error("rate deltas nonzero while invalid");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> req_valid_r)
    else $error("accepted request lost");

endmodule
